// ===== sv/tcw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    typedef enum logic [1:0] {
        REQ_PUT   = 2'd0,
        REQ_CLEAR = 2'd1,
        REQ_READ  = 2'd2,
        REQ_NOP   = 2'd3
    } req_kind_t;

    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_BLANK    = 8'h20;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7F;
    localparam int         TAB_STOP    = 8;
    localparam logic [7:0] ATTR_RESET  = 8'h0F;

    localparam int LOC_W  = 11;
    localparam int CELL_W = 16;

    typedef struct packed {
        logic              valid;
        logic [LOC_W-1:0]  cursor_pos;
        logic [CELL_W-1:0] cell_data;
    } result_t;

endpackage

`default_nettype wire

// ===== sv/tcw_cell_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_cell_mem #(
    parameter int DEPTH  = 2000,
    parameter int ADDR_W = 11
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [ADDR_W-1:0]          waddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] wdata,
    input  wire logic                       re,
    input  wire logic [ADDR_W-1:0]          raddr,
    output logic      [tcw_pkg::CELL_W-1:0] rdata
);

    logic [tcw_pkg::CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcw_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int ADDR_W  = 11
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic [1:0]                 req_type,
    input  wire logic [7:0]                 char_code,
    input  wire logic [10:0]                cell_address,
    input  wire logic [7:0]                 attr,
    output logic                            mem_we,
    output logic      [ADDR_W-1:0]          mem_waddr,
    output logic      [tcw_pkg::CELL_W-1:0] mem_wdata,
    output logic                            mem_re,
    output logic      [ADDR_W-1:0]          mem_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] mem_rdata,
    output tcw_pkg::result_t                res,
    input  wire logic                       res_take
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int SPAN  = (ROWS - 1) * COLUMNS;
    localparam int CNT_W = $clog2(CELLS + 1);
    localparam int COL_W = $clog2(COLUMNS);
    localparam int ROW_W = $clog2(ROWS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCROLL,
        ST_FILL,
        ST_RESP
    } state_t;

    state_t                     state_reg, state_next;
    logic [COL_W-1:0]           col_reg, col_next;
    logic [ROW_W-1:0]           row_reg, row_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [tcw_pkg::CELL_W-1:0] data_reg, data_next;

    logic        accept;
    logic [31:0] loc_full;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [31:0] rd_addr;
    logic [31:0] put_col;
    logic [31:0] put_row;
    logic        printable;
    logic [tcw_pkg::CELL_W-1:0] blank;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign loc_full  = 32'(row_reg) * 32'(COLUMNS) + 32'(col_reg);
    assign src_addr  = 32'(cnt_reg) + 32'(COLUMNS);
    assign dst_addr  = 32'(cnt_reg) - 32'd1;
    assign rd_addr   = {21'd0, cell_address};
    assign printable = (char_code >= tcw_pkg::CH_PRINT_LO)
                    && (char_code <= tcw_pkg::CH_PRINT_HI);
    assign blank     = {attr, tcw_pkg::CH_BLANK};

    assign res.valid      = (state_reg == ST_RESP);
    assign res.cursor_pos = loc_full[tcw_pkg::LOC_W-1:0];
    assign res.cell_data  = data_reg;

    // cursor update for a put request
    always_comb
    begin
        put_col = 32'(col_reg);
        put_row = 32'(row_reg);
        case (char_code)
            tcw_pkg::CH_BS:
            begin
                if (col_reg != '0)
                begin
                    put_col = 32'(col_reg) - 32'd1;
                end
            end
            tcw_pkg::CH_TAB:
            begin
                put_col = (32'(col_reg) + 32'(tcw_pkg::TAB_STOP))
                        & ~32'(tcw_pkg::TAB_STOP - 1);
            end
            tcw_pkg::CH_CR:
            begin
                put_col = 32'd0;
            end
            tcw_pkg::CH_LF:
            begin
                put_col = 32'd0;
                put_row = 32'(row_reg) + 32'd1;
            end
            default:
            begin
                if (printable)
                begin
                    put_col = 32'(col_reg) + 32'd1;
                end
            end
        endcase
        if (put_col >= 32'(COLUMNS))
        begin
            put_col = 32'd0;
            put_row = put_row + 32'd1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        row_next   = row_reg;
        cnt_next   = cnt_reg;
        data_next  = data_reg;
        mem_we     = 1'b0;
        mem_waddr  = loc_full[ADDR_W-1:0];
        mem_wdata  = {attr, char_code};
        mem_re     = 1'b0;
        mem_raddr  = rd_addr[ADDR_W-1:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    data_next  = '0;
                    state_next = ST_RESP;
                    case (tcw_pkg::req_kind_t'(req_type))
                        tcw_pkg::REQ_PUT:
                        begin
                            mem_we   = printable;
                            col_next = put_col[COL_W-1:0];
                            if (put_row >= 32'(ROWS))
                            begin
                                row_next   = ROW_W'(ROWS - 1);
                                cnt_next   = '0;
                                state_next = ST_SCROLL;
                            end
                            else
                            begin
                                row_next = put_row[ROW_W-1:0];
                            end
                        end
                        tcw_pkg::REQ_CLEAR:
                        begin
                            col_next   = '0;
                            row_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_FILL;
                        end
                        tcw_pkg::REQ_READ:
                        begin
                            if (rd_addr < 32'(CELLS))
                            begin
                                mem_re     = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                data_next  = mem_rdata;
                state_next = ST_RESP;
            end
            ST_SCROLL:
            begin
                // read one row ahead, write back the cell read in the previous cycle
                mem_re    = (32'(cnt_reg) < 32'(SPAN));
                mem_raddr = src_addr[ADDR_W-1:0];
                mem_we    = (cnt_reg != '0);
                mem_waddr = dst_addr[ADDR_W-1:0];
                mem_wdata = mem_rdata;
                if (32'(cnt_reg) == 32'(SPAN))
                begin
                    state_next = ST_FILL;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_FILL:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[ADDR_W-1:0];
                mem_wdata = blank;
                if (32'(cnt_reg) == 32'(CELLS - 1))
                begin
                    state_next = ST_RESP;
                end
                else
                begin
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_RESP:
            begin
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            cnt_reg   <= '0;
            data_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            cnt_reg   <= cnt_next;
            data_reg  <= data_next;
        end
    end

endmodule

`default_nettype wire

// ===== sv/text_console_writer.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Text console engine: a COLUMNS x ROWS grid of 16-bit cells (attribute byte high,
// character byte low) held in one synchronous RAM, plus a cursor. One request at a
// time: s_tready is high only while the engine is idle, and a finished result waits
// in the engine until the output register is empty or being drained, holding up the
// next request. A clear walks the RAM one cell a cycle. A put that scrolls copies the
// grid up one row through the single RAM port pair and blanks the bottom row. The
// cell RAM is not initialized by reset; cells read back only after a clear or a write.
module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // char_code[7:0], cell_address[18:8]
    input  wire logic [1:0]  s_tuser,   // req_type[1:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [31:0] m_tdata,   // cursor_pos[10:0], cell_data[26:11]
    input  wire logic        cfg_we,
    input  wire logic [7:0]  cfg_wdata
);

    localparam int CELLS  = COLUMNS * ROWS;
    localparam int ADDR_W = $clog2(CELLS);

    logic [7:0]                 attr_reg;
    logic                       m_tvalid_reg;
    logic [31:0]                m_tdata_reg;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [tcw_pkg::CELL_W-1:0] mem_wdata;
    logic                       mem_re;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [tcw_pkg::CELL_W-1:0] mem_rdata;
    tcw_pkg::result_t           res;
    logic                       res_take;

    // output slot is free when empty or being drained this cycle
    assign res_take = res.valid && (!m_tvalid_reg || m_tready);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    tcw_ctrl #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .ADDR_W  (ADDR_W)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .req_type     (s_tuser),
        .char_code    (s_tdata[7:0]),
        .cell_address (s_tdata[18:8]),
        .attr         (attr_reg),
        .mem_we       (mem_we),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_re       (mem_re),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata),
        .res          (res),
        .res_take     (res_take)
    );

    tcw_cell_mem #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg     <= tcw_pkg::ATTR_RESET;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                attr_reg <= cfg_wdata;
            end
            if (res_take)
            begin
                m_tvalid_reg <= 1'b1;
                m_tdata_reg  <= {5'd0, res.cell_data, res.cursor_pos};
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

// ===== sv/tcw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [31:0] m_tdata
);

    localparam int CELLS = COLUMNS * ROWS;

    // one request in flight: s_tready is low in the cycle after a transaction
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted on consecutive cycles");

    // reported cursor stays on the grid
    a_cursor_on_grid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (CELLS <= 2048) |-> ({21'd0, m_tdata[10:0]} < 32'(CELLS)))
    else $error("cursor location off the grid");

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
    else $error("result changed while stalled");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_tcw_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
